FILE: hdl/nmea_pkg.sv
// Shared types, character codes and constants for the NMEA position parser.
// Used by nmea_udeg_conv and nmea_position_parser; depends on nothing else.
package nmea_pkg;

  // Character codes the parser reacts to.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_E      = 8'h45;

  // Field numbers within the sentence (commas seen so far).
  localparam logic [2:0] FLD_TIME   = 3'd1;
  localparam logic [2:0] FLD_STATUS = 3'd2;
  localparam logic [2:0] FLD_LAT    = 3'd3;
  localparam logic [2:0] FLD_NS     = 3'd4;
  localparam logic [2:0] FLD_LON    = 3'd5;
  localparam logic [2:0] FLD_EW     = 3'd6;

  // Accumulator and result widths.
  localparam int TIME_W      = 18;
  localparam int LAT_WHOLE_W = 14;
  localparam int LON_WHOLE_W = 15;
  localparam int LAT_W       = 27;
  localparam int LON_W       = 28;

  localparam logic [TIME_W-1:0] TIME_MAX = 18'd235959;
  localparam int unsigned LAT_MAX_UDEG = 90000000;
  localparam int unsigned LON_MAX_UDEG = 180000000;

  // Whole-part divide by 100 as multiply and shift; exact for 15-bit values.
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_MUL_W = 13;
  localparam int DIV100_SHIFT = 19;
  localparam int DEC_100      = 100;

  // Minutes to micro-degrees: scaled minutes stay below 2**27, and a
  // 33-bit reciprocal shift is exact for divisors up to 60 at that width.
  localparam int MINX_W      = 27;
  localparam int CONV_SHIFT  = 33;
  localparam int MINQ_W      = 21;
  localparam int SUM_W       = 30;
  localparam int UDEG_PER_DEG = 1000000;

  // Power-of-ten table width (largest entry is ten to the sixth).
  localparam int POW_W = 20;

  // Load enables for the conversion pipeline stages after capture.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } conv_adv_t;

  // Result fields that ride alongside the position conversion.
  typedef struct packed {
    logic [TIME_W-1:0] utc_time;
    logic              fix_valid;
    logic              north;
    logic              east;
    logic              format_error;
  } side_t;

  // Ten to the power n for the fraction alignment at a field's end.
  function automatic logic [POW_W-1:0] pow_ten(input logic [2:0] n);
    logic [POW_W-1:0] r;
    unique case (n)
      3'd0:    r = 20'd1;
      3'd1:    r = 20'd10;
      3'd2:    r = 20'd100;
      3'd3:    r = 20'd1000;
      3'd4:    r = 20'd10000;
      3'd5:    r = 20'd100000;
      default: r = 20'd1000000;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/nmea_udeg_conv.sv
// Four-stage conversion of a ddmm.mmmm style coordinate to micro-degrees.
// Depends on nmea_pkg; stage loads come from the parser's pipeline control.
module nmea_udeg_conv
  import nmea_pkg::*;
#(
  parameter int          WHOLE_W     = 14,
  parameter int          OUT_W       = 27,
  parameter int          FRAC_DIGITS = 4,
  parameter int unsigned MAX_UDEG    = 90000000
) (
  input  logic                                   clk,
  input  conv_adv_t                              adv,
  input  logic [WHOLE_W-1:0]                     whole,
  input  logic [$clog2(10**FRAC_DIGITS)-1:0]     frac,
  output logic [OUT_W-1:0]                       udeg
);

  localparam int FW    = $clog2(10**FRAC_DIGITS);
  localparam int DEG_W = WHOLE_W - 6;
  localparam int PW    = WHOLE_W + DIV100_MUL_W;
  localparam int unsigned SCALE = 10**FRAC_DIGITS;
  // minutes * 1e6 / (60 * SCALE) reduced to x * K / D
  localparam int unsigned CONV_K  = (FRAC_DIGITS <= 4) ? 50000 / SCALE : 1;
  localparam int unsigned CONV_D  = (FRAC_DIGITS <= 4) ? 3 :
                                    ((FRAC_DIGITS == 5) ? 6 : 60);
  localparam int unsigned MIN_MUL = SCALE * CONV_K;
  localparam longint unsigned CONV_M =
    ((64'd1 << CONV_SHIFT) + 64'(CONV_D) - 64'd1) / 64'(CONV_D);

  logic [PW-1:0]      prod100;
  logic [DEG_W-1:0]   deg2;
  logic [WHOLE_W-1:0] whole2;
  logic [FW-1:0]      frac2;
  logic [WHOLE_W-1:0] rem_full;
  logic [6:0]         rem;
  logic [MINX_W-1:0]  minx;
  logic [DEG_W-1:0]   deg3;
  logic [MINX_W-1:0]  minx3;
  logic [63:0]        recip_prod;
  logic [DEG_W-1:0]   deg4;
  logic [MINQ_W-1:0]  minq4;
  logic [SUM_W-1:0]   sum;

  // Stage 2: degrees are the whole part divided by 100.
  assign prod100 = PW'(whole) * PW'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      deg2   <= prod100[DIV100_SHIFT +: DEG_W];
      whole2 <= whole;
      frac2  <= frac;
    end
  end

  // Stage 3: whole minutes, joined with the fraction and scaled by K.
  assign rem_full = whole2 - WHOLE_W'(deg2) * WHOLE_W'(DEC_100);
  assign rem      = rem_full[6:0];
  assign minx     = MINX_W'(rem) * MINX_W'(MIN_MUL) + MINX_W'(frac2) * MINX_W'(CONV_K);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      deg3  <= deg2;
      minx3 <= minx;
    end
  end

  // Stage 4: divide by D through the reciprocal.
  assign recip_prod = 64'(minx3) * CONV_M;

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      deg4  <= deg3;
      minq4 <= recip_prod[CONV_SHIFT +: MINQ_W];
    end
  end

  // Stage 5: degrees to micro-degrees plus the minute share, saturated.
  assign sum = SUM_W'(deg4) * SUM_W'(UDEG_PER_DEG) + SUM_W'(minq4);

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      if (sum > SUM_W'(MAX_UDEG)) begin
        udeg <= OUT_W'(MAX_UDEG);
      end else begin
        udeg <= sum[OUT_W-1:0];
      end
    end
  end

endmodule

FILE: hdl/nmea_position_parser.sv
// Top level of the NMEA RMC position parser: byte parser and result pipeline.
// Depends on nmea_pkg and nmea_udeg_conv.
//
// The parser takes one sentence byte per clock while byte_stall is low. A '$'
// opens a sentence and the seventh comma closes it and produces one item
// carrying the time, the fix status and both coordinates in micro-degrees; a
// '$' or CR/LF inside an open sentence produces an error item instead. Each
// item runs through a five-stage pipeline (capture, divide by 100, minutes
// scaling, reciprocal divide, final sum and saturation). Bytes are taken
// every cycle while byte_stall is low; byte_stall rises only when the
// capture stage is full and every later stage is blocked by result_stall.
// FRAC_DIGITS sets how many minute fraction digits are kept.
module nmea_position_parser
  import nmea_pkg::*;
#(
  parameter int FRAC_DIGITS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  logic [7:0]           nmea_byte,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [TIME_W-1:0]    utc_time,
  output logic                 fix_valid,
  output logic [LAT_W-1:0]     latitude_udeg,
  output logic                 north,
  output logic [LON_W-1:0]     longitude_udeg,
  output logic                 east,
  output logic                 format_error
);

  localparam int FW  = $clog2(10**FRAC_DIGITS);
  localparam int FPW = FW + 4;
  localparam int SPW = FW + POW_W;

  // Parser state.
  logic                   in_sentence, in_sentence_next;
  logic [2:0]             field_index, field_index_next;
  logic                   after_point, after_point_next;
  logic [2:0]             frac_count, frac_count_next;
  logic [TIME_W-1:0]      time_accum, time_accum_next;
  logic [LAT_WHOLE_W-1:0] lat_whole, lat_whole_next;
  logic [FW-1:0]          lat_frac, lat_frac_next;
  logic [LON_WHOLE_W-1:0] lon_whole, lon_whole_next;
  logic [FW-1:0]          lon_frac, lon_frac_next;
  logic                   valid_flag, valid_flag_next;
  logic                   north_flag, north_flag_next;
  logic                   east_flag, east_flag_next;

  // Byte decode and arithmetic helpers.
  logic                   accept;
  logic                   is_digit;
  logic [7:0]             digit_full;
  logic [3:0]             digit;
  logic                   frac_room;
  logic [TIME_W+3:0]      time_push;
  logic [LAT_WHOLE_W+3:0] lat_push;
  logic [LON_WHOLE_W+3:0] lon_push;
  logic [FPW-1:0]         lat_frac_push;
  logic [FPW-1:0]         lon_frac_push;
  logic [POW_W-1:0]       align_pow;
  logic [SPW-1:0]         lat_scaled;
  logic [SPW-1:0]         lon_scaled;
  logic                   emit;
  logic                   emit_ok;

  // Pipeline control and capture stage.
  logic                   v1, v2, v3, v4;
  logic                   rdy1, rdy2, rdy3, rdy4, rdy5;
  conv_adv_t              adv;
  side_t                  side1, side2, side3, side4, side5;
  logic [LAT_WHOLE_W-1:0] cap_lat_whole;
  logic [FW-1:0]          cap_lat_frac;
  logic [LON_WHOLE_W-1:0] cap_lon_whole;
  logic [FW-1:0]          cap_lon_frac;

  assign accept = byte_valid && !byte_stall;

  // Digit decode and accumulator candidates.
  assign is_digit   = (nmea_byte >= CH_ZERO) && (nmea_byte <= CH_NINE);
  assign digit_full = nmea_byte - CH_ZERO;
  assign digit      = is_digit ? digit_full[3:0] : 4'd0;
  assign frac_room  = frac_count < 3'(FRAC_DIGITS);

  assign time_push = (TIME_W+4)'(time_accum) * (TIME_W+4)'(10) + (TIME_W+4)'(digit);
  assign lat_push  = (LAT_WHOLE_W+4)'(lat_whole) * (LAT_WHOLE_W+4)'(10)
                   + (LAT_WHOLE_W+4)'(digit);
  assign lon_push  = (LON_WHOLE_W+4)'(lon_whole) * (LON_WHOLE_W+4)'(10)
                   + (LON_WHOLE_W+4)'(digit);
  assign lat_frac_push = FPW'(lat_frac) * FPW'(10) + FPW'(digit);
  assign lon_frac_push = FPW'(lon_frac) * FPW'(10) + FPW'(digit);

  // Missing fraction digits are filled with zeros when the field closes.
  assign align_pow  = pow_ten(3'(FRAC_DIGITS) - frac_count);
  assign lat_scaled = SPW'(lat_frac) * SPW'(align_pow);
  assign lon_scaled = SPW'(lon_frac) * SPW'(align_pow);

  // Next parser state for the accepted byte.
  always_comb begin
    in_sentence_next = in_sentence;
    field_index_next = field_index;
    after_point_next = after_point;
    frac_count_next  = frac_count;
    time_accum_next  = time_accum;
    lat_whole_next   = lat_whole;
    lat_frac_next    = lat_frac;
    lon_whole_next   = lon_whole;
    lon_frac_next    = lon_frac;
    valid_flag_next  = valid_flag;
    north_flag_next  = north_flag;
    east_flag_next   = east_flag;
    if (accept) begin
      priority if (nmea_byte == CH_DOLLAR) begin
        in_sentence_next = 1'b1;
        field_index_next = 3'd0;
        after_point_next = 1'b0;
        frac_count_next  = 3'd0;
        time_accum_next  = '0;
        lat_whole_next   = '0;
        lat_frac_next    = '0;
        lon_whole_next   = '0;
        lon_frac_next    = '0;
        north_flag_next  = 1'b0;
        east_flag_next   = 1'b0;
      end else if (!in_sentence) begin
        in_sentence_next = 1'b0;
      end else if (nmea_byte == CH_CR || nmea_byte == CH_LF) begin
        in_sentence_next = 1'b0;
      end else if (nmea_byte == CH_COMMA) begin
        if (field_index == FLD_LAT) begin
          lat_frac_next = lat_scaled[FW-1:0];
        end else if (field_index == FLD_LON) begin
          lon_frac_next = lon_scaled[FW-1:0];
        end
        if (field_index == FLD_EW) begin
          in_sentence_next = 1'b0;
        end else begin
          field_index_next = field_index + 3'd1;
          after_point_next = 1'b0;
          frac_count_next  = 3'd0;
        end
      end else begin
        unique case (field_index)
          FLD_TIME: begin
            if (nmea_byte == CH_POINT) begin
              after_point_next = 1'b1;
            end else if (is_digit && !after_point) begin
              time_accum_next = time_push[TIME_W-1:0];
              if (time_push[TIME_W+3:TIME_W] != 4'd0) begin
                time_accum_next = '1;
              end
            end
          end
          FLD_LAT: begin
            if (nmea_byte == CH_POINT) begin
              after_point_next = 1'b1;
            end else if (is_digit && after_point) begin
              if (frac_room) begin
                frac_count_next = frac_count + 3'd1;
                lat_frac_next   = lat_frac_push[FW-1:0];
              end
            end else if (is_digit) begin
              lat_whole_next = lat_push[LAT_WHOLE_W-1:0];
              if (lat_push[LAT_WHOLE_W+3:LAT_WHOLE_W] != 4'd0) begin
                lat_whole_next = '1;
              end
            end
          end
          FLD_LON: begin
            if (nmea_byte == CH_POINT) begin
              after_point_next = 1'b1;
            end else if (is_digit && after_point) begin
              if (frac_room) begin
                frac_count_next = frac_count + 3'd1;
                lon_frac_next   = lon_frac_push[FW-1:0];
              end
            end else if (is_digit) begin
              lon_whole_next = lon_push[LON_WHOLE_W-1:0];
              if (lon_push[LON_WHOLE_W+3:LON_WHOLE_W] != 4'd0) begin
                lon_whole_next = '1;
              end
            end
          end
          FLD_STATUS: begin
            if (!after_point) begin
              if (nmea_byte == CH_A) begin
                valid_flag_next = 1'b1;
              end else if (nmea_byte == CH_V) begin
                valid_flag_next = 1'b0;
              end
              after_point_next = 1'b1;
            end
          end
          FLD_NS: begin
            if (!after_point) begin
              north_flag_next  = (nmea_byte == CH_N);
              after_point_next = 1'b1;
            end
          end
          FLD_EW: begin
            if (!after_point) begin
              east_flag_next   = (nmea_byte == CH_E);
              after_point_next = 1'b1;
            end
          end
          default: begin
            after_point_next = after_point;
          end
        endcase
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence <= 1'b0;
      field_index <= 3'd0;
      after_point <= 1'b0;
      frac_count  <= 3'd0;
      time_accum  <= '0;
      lat_whole   <= '0;
      lat_frac    <= '0;
      lon_whole   <= '0;
      lon_frac    <= '0;
      valid_flag  <= 1'b0;
      north_flag  <= 1'b0;
      east_flag   <= 1'b0;
    end else begin
      in_sentence <= in_sentence_next;
      field_index <= field_index_next;
      after_point <= after_point_next;
      frac_count  <= frac_count_next;
      time_accum  <= time_accum_next;
      lat_whole   <= lat_whole_next;
      lat_frac    <= lat_frac_next;
      lon_whole   <= lon_whole_next;
      lon_frac    <= lon_frac_next;
      valid_flag  <= valid_flag_next;
      north_flag  <= north_flag_next;
      east_flag   <= east_flag_next;
    end
  end

  // An item leaves the parser at the seventh comma or at an early end.
  assign emit_ok = in_sentence && (nmea_byte == CH_COMMA) && (field_index == FLD_EW);
  assign emit    = accept && in_sentence &&
                   ((nmea_byte == CH_DOLLAR) || (nmea_byte == CH_CR) ||
                    (nmea_byte == CH_LF) || emit_ok);

  // Ready chain: a stage may load when it is empty or its item moves on.
  assign rdy5 = !result_valid || !result_stall;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign byte_stall = !rdy1;

  assign adv.s2 = rdy2 && v1;
  assign adv.s3 = rdy3 && v2;
  assign adv.s4 = rdy4 && v3;
  assign adv.s5 = rdy5 && v4;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= emit;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        result_valid <= v4;
      end
    end
  end

  // Capture stage: an error item carries zeros everywhere else.
  always_ff @(posedge clk) begin
    if (emit) begin
      if (emit_ok) begin
        side1.utc_time     <= (time_accum > TIME_MAX) ? TIME_MAX : time_accum;
        side1.fix_valid    <= valid_flag;
        side1.north        <= north_flag;
        side1.east         <= east_flag;
        side1.format_error <= 1'b0;
        cap_lat_whole      <= lat_whole;
        cap_lat_frac       <= lat_frac;
        cap_lon_whole      <= lon_whole;
        cap_lon_frac       <= lon_frac;
      end else begin
        side1         <= side_t'{utc_time: '0, fix_valid: 1'b0, north: 1'b0,
                                 east: 1'b0, format_error: 1'b1};
        cap_lat_whole <= '0;
        cap_lat_frac  <= '0;
        cap_lon_whole <= '0;
        cap_lon_frac  <= '0;
      end
    end
  end

  // Side fields follow the conversion stages.
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      side2 <= side1;
    end
    if (adv.s3) begin
      side3 <= side2;
    end
    if (adv.s4) begin
      side4 <= side3;
    end
    if (adv.s5) begin
      side5 <= side4;
    end
  end

  // Coordinate converters.
  nmea_udeg_conv #(
    .WHOLE_W     (LAT_WHOLE_W),
    .OUT_W       (LAT_W),
    .FRAC_DIGITS (FRAC_DIGITS),
    .MAX_UDEG    (LAT_MAX_UDEG)
  ) u_lat_conv (
    .clk   (clk),
    .adv   (adv),
    .whole (cap_lat_whole),
    .frac  (cap_lat_frac),
    .udeg  (latitude_udeg)
  );

  nmea_udeg_conv #(
    .WHOLE_W     (LON_WHOLE_W),
    .OUT_W       (LON_W),
    .FRAC_DIGITS (FRAC_DIGITS),
    .MAX_UDEG    (LON_MAX_UDEG)
  ) u_lon_conv (
    .clk   (clk),
    .adv   (adv),
    .whole (cap_lon_whole),
    .frac  (cap_lon_frac),
    .udeg  (longitude_udeg)
  );

  assign utc_time     = side5.utc_time;
  assign fix_valid    = side5.fix_valid;
  assign north        = side5.north;
  assign east         = side5.east;
  assign format_error = side5.format_error;

  // An error item carries nothing but the error flag.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && format_error |-> utc_time == '0 && !fix_valid && !north &&
      !east && latitude_udeg == '0 && longitude_udeg == '0)
    else $error("error item carries nonzero fields");

  // Delivered values stay within their ranges.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> utc_time <= TIME_MAX &&
      latitude_udeg <= LAT_W'(LAT_MAX_UDEG) && longitude_udeg <= LON_W'(LON_MAX_UDEG))
    else $error("result out of range");

  // The seventh comma loads a good item into the capture stage.
  a_seventh_comma: assert property (@(posedge clk) disable iff (rst)
    accept && emit_ok |=> v1 && !side1.format_error)
    else $error("seventh comma did not capture an item");

  // Stray bytes outside a sentence never open one.
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    accept && !in_sentence && nmea_byte != CH_DOLLAR |=> !in_sentence)
    else $error("sentence opened without a dollar sign");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for nmea_position_parser: byte streams of RMC sentences go in,
// and every result is checked against a predictor kept inside the bench.
// Depends on nmea_pkg and the parser RTL only.
module tb;
  import nmea_pkg::*;

  localparam int FRAC_DIGITS     = 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 340;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_W    = 8'h57;
  localparam longint unsigned TIME_SAT      = (2 ** TIME_W) - 1;
  localparam longint unsigned LAT_WHOLE_SAT = (2 ** LAT_WHOLE_W) - 1;
  localparam longint unsigned LON_WHOLE_SAT = (2 ** LON_WHOLE_W) - 1;

  // One position fix as it leaves the parser.
  typedef struct packed {
    logic [TIME_W-1:0] utc_time;
    logic              fix_valid;
    logic [LAT_W-1:0]  latitude_udeg;
    logic              north;
    logic [LON_W-1:0]  longitude_udeg;
    logic              east;
    logic              format_error;
  } fix_t;

  // Tracks the sentence state, predicts the fixes and checks what comes out.
  class fix_tracker;
    fix_t pending_fixes[$];
    int mismatches;
    int checked;
    int errors_due;
    int results_due;
    bit in_sent;
    bit [2:0] fld;
    bit after_pt;
    int frac_n;
    bit [TIME_W-1:0] time_acc;
    bit [LAT_WHOLE_W-1:0] lat_w;
    bit [13:0] lat_f;
    bit [LON_WHOLE_W-1:0] lon_w;
    bit [13:0] lon_f;
    bit valid_f;
    bit north_f;
    bit east_f;

    function void open_sentence();
      in_sent  = 1'b1;
      fld      = '0;
      after_pt = 1'b0;
      frac_n   = 0;
      time_acc = '0;
      lat_w    = '0;
      lat_f    = '0;
      lon_w    = '0;
      lon_f    = '0;
      north_f  = 1'b0;
      east_f   = 1'b0;
    endfunction

    function longint unsigned ten_pow(int n);
      longint unsigned r;
      r = 1;
      for (int i = 0; i < n; i++) r = r * 10;
      return r;
    endfunction

    // Decimal shift-in with saturation.
    function longint unsigned shift_in_digit(longint unsigned v, int d, longint unsigned sat);
      longint unsigned n;
      n = v * 10 + d;
      return (n > sat) ? sat : n;
    endfunction

    // Minute fraction digits beyond FRAC_DIGITS are dropped.
    function longint unsigned frac_in(longint unsigned f, int d);
      if (frac_n < FRAC_DIGITS) begin
        frac_n++;
        return f * 10 + d;
      end
      return f;
    endfunction

    // ddmm.mmmm to micro-degrees, truncated and saturated.
    function longint unsigned to_microdeg(longint unsigned whole, longint unsigned frac,
                                          longint unsigned sat);
      longint unsigned scale, deg, mins, u;
      scale = ten_pow(FRAC_DIGITS);
      deg   = whole / 100;
      mins  = (whole % 100) * scale + frac;
      u     = deg * 1000000 + (mins * 1000000) / (60 * scale);
      return (u > sat) ? sat : u;
    endfunction

    function void expect_error();
      fix_t e;
      e = '0;
      e.format_error = 1'b1;
      pending_fixes.push_back(e);
      errors_due++;
      results_due++;
    endfunction

    // Notes one accepted byte; returns 0 when the byte was ignored.
    function bit take_byte(logic [7:0] b);
      fix_t r;
      bit digit;
      int d;
      if (b == CH_DOLLAR) begin
        if (in_sent) expect_error();
        open_sentence();
        return 1'b1;
      end
      if (!in_sent) return 1'b0;
      if (b == CH_CR || b == CH_LF) begin
        expect_error();
        in_sent = 1'b0;
        return 1'b1;
      end
      if (b == CH_COMMA) begin
        if (fld == FLD_LAT) lat_f = 14'(lat_f * ten_pow(FRAC_DIGITS - frac_n));
        else if (fld == FLD_LON) lon_f = 14'(lon_f * ten_pow(FRAC_DIGITS - frac_n));
        if (fld == FLD_EW) begin
          r.utc_time       = (time_acc > TIME_MAX) ? TIME_MAX : time_acc;
          r.fix_valid      = valid_f;
          r.latitude_udeg  = LAT_W'(to_microdeg(lat_w, lat_f, LAT_MAX_UDEG));
          r.north          = north_f;
          r.longitude_udeg = LON_W'(to_microdeg(lon_w, lon_f, LON_MAX_UDEG));
          r.east           = east_f;
          r.format_error   = 1'b0;
          pending_fixes.push_back(r);
          results_due++;
          in_sent = 1'b0;
          return 1'b1;
        end
        fld      = fld + 3'd1;
        after_pt = 1'b0;
        frac_n   = 0;
        return 1'b1;
      end
      digit = (b >= CH_ZERO && b <= CH_NINE);
      d = digit ? int'(b - CH_ZERO) : 0;
      case (fld)
        FLD_TIME, FLD_LAT, FLD_LON: begin
          if (b == CH_POINT) begin
            after_pt = 1'b1;
          end else if (digit) begin
            if (fld == FLD_TIME) begin
              if (!after_pt) time_acc = TIME_W'(shift_in_digit(time_acc, d, TIME_SAT));
            end else if (fld == FLD_LAT) begin
              if (after_pt) lat_f = 14'(frac_in(lat_f, d));
              else lat_w = LAT_WHOLE_W'(shift_in_digit(lat_w, d, LAT_WHOLE_SAT));
            end else begin
              if (after_pt) lon_f = 14'(frac_in(lon_f, d));
              else lon_w = LON_WHOLE_W'(shift_in_digit(lon_w, d, LON_WHOLE_SAT));
            end
          end
        end
        // Single-character fields: only the first byte counts.
        FLD_STATUS: begin
          if (!after_pt) begin
            if (b == CH_A) valid_f = 1'b1;
            else if (b == CH_V) valid_f = 1'b0;
            after_pt = 1'b1;
          end
        end
        FLD_NS: begin
          if (!after_pt) begin
            north_f  = (b == CH_N);
            after_pt = 1'b1;
          end
        end
        FLD_EW: begin
          if (!after_pt) begin
            east_f   = (b == CH_E);
            after_pt = 1'b1;
          end
        end
        default: ;
      endcase
      return 1'b1;
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compares one result against the oldest expected fix.
    function void check_fix(fix_t got);
      fix_t want;
      checked++;
      if (pending_fixes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual time %0d error %0d",
                 $time, got.utc_time, got.format_error);
        return;
      end
      want = pending_fixes.pop_front();
      check_field("utc_time", want.utc_time, got.utc_time);
      check_field("fix_valid", want.fix_valid, got.fix_valid);
      check_field("latitude_udeg", want.latitude_udeg, got.latitude_udeg);
      check_field("north", want.north, got.north);
      check_field("longitude_udeg", want.longitude_udeg, got.longitude_udeg);
      check_field("east", want.east, got.east);
      check_field("format_error", want.format_error, got.format_error);
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  logic [7:0]          nmea_byte = 8'h00;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [TIME_W-1:0]   utc_time;
  logic                fix_valid;
  logic [LAT_W-1:0]    latitude_udeg;
  logic                north;
  logic [LON_W-1:0]    longitude_udeg;
  logic                east;
  logic                format_error;

  fix_tracker sb;
  fix_t seen_fix;
  logic [7:0] line_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_total = 0;
  int items_phase = 0;
  int cycle_count;

  nmea_position_parser #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .nmea_byte(nmea_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .utc_time(utc_time),
    .fix_valid(fix_valid),
    .latitude_udeg(latitude_udeg),
    .north(north),
    .longitude_udeg(longitude_udeg),
    .east(east),
    .format_error(format_error)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle counter that ends a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timed out with %0d fixes still expected", $time, sb.pending_fixes.size());
    $display("simulation failed");
    $finish;
  end

  // Random back-pressure on the result side.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      seen_fix.utc_time       = utc_time;
      seen_fix.fix_valid      = fix_valid;
      seen_fix.latitude_udeg  = latitude_udeg;
      seen_fix.north          = north;
      seen_fix.longitude_udeg = longitude_udeg;
      seen_fix.east           = east;
      seen_fix.format_error   = format_error;
      sb.check_fix(seen_fix);
    end
  end

  // Drives one byte with random idle cycles ahead of it and waits for acceptance.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    nmea_byte  <= b;
    do @(posedge clk); while (byte_stall);
    void'(sb.take_byte(b));
    items_total++;
    items_phase++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_text(input string s, input logic [7:0] ending);
    add_text(s);
    line_q.push_back(ending);
    send_line();
  endtask

  // Random digits, with an occasional stray byte of any value.
  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0) line_q.push_back(8'($urandom_range(0, 255)));
      else line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // Whole digits, mostly the usual count, then an optional fraction.
  task automatic add_number(input int usual, input int most, input int frac_most);
    add_digits(($urandom_range(0, 3) != 0) ? usual : $urandom_range(0, most));
    if ($urandom_range(0, 4) != 0) begin
      line_q.push_back(CH_POINT);
      add_digits($urandom_range(0, frac_most));
    end
    line_q.push_back(CH_COMMA);
  endtask

  // One-letter field: mostly one of the two legal letters, sometimes junk or empty.
  task automatic add_flag(input logic [7:0] yes, input logic [7:0] no);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) line_q.push_back(yes);
    else if (pick < 8) line_q.push_back(no);
    else if (pick == 8) line_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
    if ($urandom_range(0, 7) == 0) line_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
    line_q.push_back(CH_COMMA);
  endtask

  // Builds a random sentence: mostly well formed, some cut short, some noise.
  task automatic build_sentence();
    int kind;
    int cut;
    int pick;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    add_text(($urandom_range(0, 3) == 0) ? "$GNRMC," : "$GPRMC,");
    add_number(6, 9, 3);
    add_flag(CH_A, CH_V);
    add_number(4, 7, 7);
    add_flag(CH_N, CH_S);
    add_number(5, 8, 7);
    add_flag(CH_E, CH_W);
    if (kind >= 75) begin
      cut = $urandom_range(1, line_q.size() - 1);
      while (line_q.size() > cut) void'(line_q.pop_back());
      pick = $urandom_range(0, 2);
      line_q.push_back((pick == 0) ? CH_CR : (pick == 1) ? CH_LF : CH_DOLLAR);
    end else begin
      add_text("022.4,084.4,230394,003.1,W*6A");
      line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
    end
  endtask

  // Holds the sender until every expected fix has come out.
  task automatic drain();
    byte_valid <= 1'b0;
    while (sb.pending_fixes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    int phase;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sentences: typical, extremes, saturation, empty fields and breaks.
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A",
              CH_CR);
    send_text("$GPRMC,235959.99,V,9000.0000,S,18000.0000,W,", CH_LF);
    send_text("$GPRMC,999999,X,9959.9999,N,99999.99999,E,", CH_CR);
    send_text("$GPRMC,1234567890,,1234567890.123456789,Q,123456789012.1.2,,", CH_CR);
    send_text("$GPRMC,,,,,,,", CH_LF);
    send_text("$GP,12,A,45$GPRMC,000000,A,0000.0001,N,00000.0001,E,", CH_CR);
    send_text("$GPRMC,0102", CH_CR);
    send_text("$GPRMC,01,V", CH_LF);
    send_text("garbage,,,,,,,A", CH_CR);
    send_text("$GPRMC,12a3:4,A,12x34.5b6,N,0/1234.5,E,", CH_LF);
    send_text("$GPRMC,.5,Vx,.99,NS,.,Ex,", CH_CR);
    drain();

    // Random sentences under three idle mixes, drained between mixes.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      items_phase = 0;
      while (items_phase < ITEMS_PER_PHASE) begin
        build_sentence();
        send_line();
      end
      drain();
    end

    $display("Sent %0d sentence bytes under three idle mixes with a full drain after each.",
             items_total);
    $display("%0d fixes expected, %0d checked, %0d of them error items.",
             sb.results_due, sb.checked, sb.errors_due);
    if (sb.mismatches == 0 && sb.pending_fixes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
